FILE: hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the 64-bit Feistel block cipher
// Holds the round constants, register index codes, the word-pair type and
// the rotate and key-offset helpers used by the key schedule and the rounds.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int WORD_W = 32;
   localparam int MULT_W = 15;

   localparam logic [MULT_W-1:0] MULT_GOOD = 15'd31337;
   localparam logic [MULT_W-1:0] MULT_BAD  = 15'd31336;
   localparam logic [WORD_W-1:0] ADD_CONST = 32'h1234_5678;
   localparam logic [WORD_W-1:0] GOLDEN    = 32'h9E37_79B9;
   localparam logic [4:0]        F_ROT     = 5'd5;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_KEY_SEED     = 2'd0,
      CSR_DECRYPT_MODE = 2'd1,
      CSR_AUTH_VALID   = 2'd2
   } csr_index_type;

   // left and right halves of one block
   typedef struct packed {
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } half_pair_type;

   // rotate a word left by amount bits
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [4:0] amount);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} << amount;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

   // idx * GOLDEN mod 2^32, evaluated at elaboration
   function automatic logic [WORD_W-1:0] key_offset(input int idx);
      logic [63:0] prod;
      prod = 64'(idx) * {32'd0, GOLDEN};
      return prod[WORD_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/fbc_key_sched.sv
// ----------------------------------------------------------------------------
// fbc_key_sched: configuration registers and round key table
// Holds the seed, mode and auth registers and keeps one registered key per
// round, already placed in the order the round pipeline consumes them.
// ----------------------------------------------------------------------------
module fbc_key_sched #(
   parameter int ROUNDS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  fbc_pkg::csr_index_type        csr_index,
   input  logic [fbc_pkg::WORD_W-1:0]    csr_wdata,
   output logic [ROUNDS-1:0][fbc_pkg::WORD_W-1:0] round_key,
   output logic                          mult_bad
);
   import fbc_pkg::*;

   logic [WORD_W-1:0]             seed_ff, seed_in;
   logic                          decrypt_ff, decrypt_in;
   logic                          auth_ff, auth_in;
   logic [ROUNDS-1:0][WORD_W-1:0] raw_key;
   logic [ROUNDS-1:0][WORD_W-1:0] key_ff, key_in;
   logic                          mult_bad_ff, mult_bad_in;

   // decode register writes; unknown indexes drop the write
   always_comb begin
      seed_in    = seed_ff;
      decrypt_in = decrypt_ff;
      auth_in    = auth_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_SEED:     seed_in    = csr_wdata;
            CSR_DECRYPT_MODE: decrypt_in = csr_wdata[0];
            CSR_AUTH_VALID:   auth_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         decrypt_ff <= 1'b0;
         auth_ff    <= 1'b1;
      end else begin
         seed_ff    <= seed_in;
         decrypt_ff <= decrypt_in;
         auth_ff    <= auth_in;
      end
   end

   // derive each round key and order it for the selected direction
   for (genvar i = 0; i < ROUNDS; i++) begin : g_key
      assign raw_key[i] = rotl(seed_ff, 5'((3 * i) % 32)) + key_offset(i);
   end

   for (genvar j = 0; j < ROUNDS; j++) begin : g_order
      assign key_in[j] = decrypt_ff ? raw_key[ROUNDS-1-j] : raw_key[j];
   end

   assign mult_bad_in = decrypt_ff & ~auth_ff;

   // hold keys in registers so the round path starts from a flop
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      mult_bad_ff <= mult_bad_in;
   end

   assign round_key = key_ff;
   assign mult_bad  = mult_bad_ff;

endmodule

FILE: hw/rtl/fbc_round.sv
// ----------------------------------------------------------------------------
// fbc_round: one Feistel round in two register stages
// Stage A mixes the key into the right half and multiplies; stage B adds the
// constant, rotates, folds into the left half and swaps the halves.
// ----------------------------------------------------------------------------
module fbc_round (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  fbc_pkg::half_pair_type        in_pair,
   input  logic [fbc_pkg::WORD_W-1:0]    round_key,
   input  logic                          mult_bad,
   output logic                          out_valid,
   output fbc_pkg::half_pair_type        out_pair
);
   import fbc_pkg::*;

   logic                 valid_a_ff;
   half_pair_type        pair_a_ff;
   logic [WORD_W-1:0]    prod_a_ff, prod_a_in;
   logic [WORD_W-1:0]    mult_word;
   logic                 valid_b_ff;
   half_pair_type        pair_b_ff, pair_b_in;
   logic [WORD_W-1:0]    f_val;

   // stage A: (R xor k) * m, low word only
   assign mult_word = {{(WORD_W-MULT_W){1'b0}}, (mult_bad ? MULT_BAD : MULT_GOOD)};
   assign prod_a_in = (in_pair.right ^ round_key) * mult_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pair_a_ff <= in_pair;
      prod_a_ff <= prod_a_in;
   end

   // stage B: finish F and swap halves
   assign f_val           = rotl(prod_a_ff + ADD_CONST, F_ROT);
   assign pair_b_in.left  = pair_a_ff.right;
   assign pair_b_in.right = pair_a_ff.left ^ f_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      pair_b_ff <= pair_b_in;
   end

   assign out_valid = valid_b_ff;
   assign out_pair  = pair_b_ff;

endmodule

FILE: hw/rtl/feistel_block_cipher_64.sv
// ----------------------------------------------------------------------------
// feistel_block_cipher_64: pipelined 64-bit Feistel block transform
// rsp_valid is registered: a taken request passes an input register, then two
// stages per round, before its result comes out.
// Throughput: one request per cycle; busy stays low, rsp_ is never stalled.
// Reset clears all valid bits and loads seed 0, encrypt mode, auth valid.
// Config writes are held off in a cycle that start is high.
// ----------------------------------------------------------------------------
module feistel_block_cipher_64 #(
   parameter int ROUNDS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fbc_pkg::WORD_W-1:0]    req_left_word,
   input  logic [fbc_pkg::WORD_W-1:0]    req_right_word,
   output logic                          rsp_valid,
   output logic [fbc_pkg::WORD_W-1:0]    rsp_left_out,
   output logic [fbc_pkg::WORD_W-1:0]    rsp_right_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fbc_pkg::csr_index_type        csr_index,
   input  logic [fbc_pkg::WORD_W-1:0]    csr_wdata
);
   import fbc_pkg::*;

   logic                          in_valid_ff;
   half_pair_type                 in_pair_ff;
   logic [ROUNDS-1:0][WORD_W-1:0] round_key;
   logic                          mult_bad;
   logic [ROUNDS:0]               stage_valid;
   half_pair_type                 stage_pair [ROUNDS+1];

   assign busy      = 1'b0;
   assign csr_ready = ~start;

   fbc_key_sched #(
      .ROUNDS (ROUNDS)
   ) u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .round_key (round_key),
      .mult_bad  (mult_bad)
   );

   // register the incoming request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      in_pair_ff.left  <= req_left_word;
      in_pair_ff.right <= req_right_word;
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_pair[0]  = in_pair_ff;

   // chain the rounds
   for (genvar j = 0; j < ROUNDS; j++) begin : g_round
      fbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[j]),
         .in_pair   (stage_pair[j]),
         .round_key (round_key[j]),
         .mult_bad  (mult_bad),
         .out_valid (stage_valid[j+1]),
         .out_pair  (stage_pair[j+1])
      );
   end

   // final swap of the halves
   assign rsp_valid     = stage_valid[ROUNDS];
   assign rsp_left_out  = stage_pair[ROUNDS].right;
   assign rsp_right_out = stage_pair[ROUNDS].left;

endmodule

FILE: hw/rtl/fbc_checker.sv
// ----------------------------------------------------------------------------
// fbc_checker: port-level checks for the Feistel block cipher
// Watches the top-level ports for pipeline timing, reset and handshake rules.
// ----------------------------------------------------------------------------
module fbc_checker #(
   parameter int ROUNDS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        csr_ready
);
   // edges from the one that takes a request to the one that takes its result:
   // the input register, then two stages per round
   localparam int LAT   = 2 * ROUNDS + 1;
   localparam int CNT_W = $clog2(LAT + 2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LAT + 1);

   logic [CNT_W-1:0] age_ff, age_in;
   logic             accept;

   assign accept = start & ~busy & ~reset;

   // count cycles since reset, saturate once the pipeline has drained
   assign age_in = (age_ff == CNT_MAX) ? age_ff : age_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else begin
         age_ff <= age_in;
      end
   end

   // every accepted request yields exactly one result strobe, and no strobe comes without one
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (age_ff == CNT_MAX) |-> (rsp_valid == $past(accept, LAT)))
      else $error("result strobe does not match request %0d cycles earlier", LAT);

   // reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // the block never holds off requests
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // a config write never lands on the edge that takes a request
   a_csr_vs_req: assert property (@(posedge clock) disable iff (reset)
      !(csr_ready && start))
      else $error("config port ready while a request enters");

endmodule

bind feistel_block_cipher_64 fbc_checker #(.ROUNDS(ROUNDS)) u_fbc_checker (.*);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for feistel_block_cipher_64
// Drives 64-bit blocks through the command port and predicts each result with
// a behavioral Feistel transform that tracks the register writes. Runs
// directed corner blocks, then randomized phases with random register
// settings and random sender gaps. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module testbench;
   import fbc_pkg::*;

   localparam int CIPHER_ROUNDS = 16;
   localparam int PIPE_LATENCY  = 2 * CIPHER_ROUNDS;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BLOCKS  = 125;

   // index that maps to no register
   localparam csr_index_type CSR_UNMAPPED = csr_index_type'(2'd3);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [WORD_W-1:0]   req_left_word;
   logic [WORD_W-1:0]   req_right_word;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_left_out;
   logic [WORD_W-1:0]   rsp_right_out;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [WORD_W-1:0]   csr_wdata;

   int unsigned         stall_cycles;

   feistel_block_cipher_64 #(.ROUNDS(CIPHER_ROUNDS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_left_word  (req_left_word),
      .req_right_word (req_right_word),
      .rsp_valid      (rsp_valid),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Tracks the cipher settings and the ciphertext blocks still owed.
   class block_scoreboard;
      logic [WORD_W-1:0] seed;
      logic              decrypt;
      logic              auth_ok;
      half_pair_type     cipher_q[$];
      int                error_count;

      function new();
         seed        = '0;
         decrypt     = 1'b0;
         auth_ok     = 1'b1;
         error_count = 0;
      endfunction

      function automatic logic [WORD_W-1:0] rotate_left32(input logic [WORD_W-1:0] x,
                                                          input int unsigned amount);
         int unsigned s;
         s = amount & 31;
         if (s == 0) return x;
         return (x << s) | (x >> (32 - s));
      endfunction

      function automatic logic [WORD_W-1:0] subkey(input int unsigned idx);
         logic [WORD_W-1:0] idx_word;
         logic [WORD_W-1:0] offset;
         idx_word = idx;
         offset   = idx_word * GOLDEN;
         return rotate_left32(seed, (3 * idx) & 31) + offset;
      endfunction

      // Run all rounds and the final swap on one block.
      function automatic half_pair_type cipher_block(input logic [WORD_W-1:0] l_in,
                                                     input logic [WORD_W-1:0] r_in);
         logic [WORD_W-1:0] l;
         logic [WORD_W-1:0] r;
         logic [WORD_W-1:0] mult;
         logic [WORD_W-1:0] mixed;
         logic [WORD_W-1:0] nr;
         int unsigned       k;
         half_pair_type     res;
         l    = l_in;
         r    = r_in;
         mult = {17'd0, (decrypt && !auth_ok) ? MULT_BAD : MULT_GOOD};
         for (int unsigned i = 0; i < CIPHER_ROUNDS; i++) begin
            k     = decrypt ? (CIPHER_ROUNDS - 1 - i) : i;
            mixed = ((r ^ subkey(k)) * mult) + ADD_CONST;
            nr    = l ^ rotate_left32(mixed, 5);
            l     = r;
            r     = nr;
         end
         res.left  = r;
         res.right = l;
         return res;
      endfunction

      function void note_config(input csr_index_type idx, input logic [WORD_W-1:0] data);
         case (idx)
            CSR_KEY_SEED:     seed    = data;
            CSR_DECRYPT_MODE: decrypt = data[0];
            CSR_AUTH_VALID:   auth_ok = data[0];
            default: ;
         endcase
      endfunction

      function void note_request(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
         cipher_q.push_back(cipher_block(l, r));
      endfunction

      function int pending();
         return cipher_q.size();
      endfunction

      task report_mismatch(input string msg);
         $display("ERROR @%0t: %s", $time, msg);
         error_count++;
      endtask

      task check_response(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
         half_pair_type want;
         if (cipher_q.size() == 0) begin
            report_mismatch($sformatf("response %h_%h with no request pending", l, r));
         end else begin
            want = cipher_q.pop_front();
            if (l !== want.left)
               report_mismatch($sformatf("left_out got %h want %h", l, want.left));
            if (r !== want.right)
               report_mismatch($sformatf("right_out got %h want %h", r, want.right));
         end
      endtask
   endclass

   block_scoreboard sb = new();

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // check every response strobe against the oldest expected block
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_response(rsp_left_out, rsp_right_out);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR @%0t: watchdog expired, %0d blocks pending", $time,
                     sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Present one request and hold it until taken; leave start high.
   task send_block(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
      start          <= 1'b1;
      req_left_word  <= l;
      req_right_word <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(l, r);
   endtask

   // Drop start for a random burst now and then.
   task sender_gap(input bit enable);
      if (enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop sending and hold until every expected block is back.
   task drain_pipeline();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write one register; leave csr_valid high for back-to-back writes.
   task write_csr(input csr_index_type idx, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(idx, data);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      bit idle_on;
      reset          = 1'b1;
      start          = 1'b0;
      req_left_word  = '0;
      req_right_word = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_KEY_SEED;
      csr_wdata      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner blocks under reset settings
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'hFFFF_FFFF, 32'h0000_0000);
      send_block(32'h0000_0000, 32'hFFFF_FFFF);
      send_block(32'hAAAA_AAAA, 32'h5555_5555);
      send_block(32'h0000_0001, 32'h8000_0000);
      drain_pipeline();

      // decrypt with all-ones seed and the bad multiplier
      write_csr(CSR_KEY_SEED, 32'hFFFF_FFFF);
      write_csr(CSR_DECRYPT_MODE, 32'h0000_0001);
      write_csr(CSR_AUTH_VALID, 32'h0000_0000);
      csr_valid <= 1'b0;
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);
      send_block(32'h8000_0000, 32'h0000_0001);
      drain_pipeline();

      // decrypt with the good multiplier; upper data bits must be dropped
      write_csr(CSR_AUTH_VALID, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_block(32'h1234_5678, 32'h9E37_79B9);
      send_block(32'hFFFF_FFFF, 32'h0000_0000);
      drain_pipeline();

      // encrypt while auth is clear: the multiplier stays good
      write_csr(CSR_DECRYPT_MODE, 32'hFFFF_FFFE);
      write_csr(CSR_AUTH_VALID, 32'hFFFF_FFFE);
      csr_valid <= 1'b0;
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_pipeline();

      // writes to the unmapped index leave every register alone
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED, 32'h0000_0000);
      csr_valid <= 1'b0;
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hC0FF_EE00, 32'h0123_4567);
      drain_pipeline();

      // random phases, each with its own settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0:       write_csr(CSR_KEY_SEED, 32'h0000_0000);
            1:       write_csr(CSR_KEY_SEED, 32'hFFFF_FFFF);
            default: write_csr(CSR_KEY_SEED, $urandom);
         endcase
         write_csr(CSR_DECRYPT_MODE, $urandom);
         write_csr(CSR_AUTH_VALID, $urandom);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_UNMAPPED, $urandom);
         csr_valid <= 1'b0;

         // no gaps in the last phase, and none in some others
         idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            sender_gap(idle_on);
            send_block(pick_word(), pick_word());
            if (n == PHASE_BLOCKS / 2 && $urandom_range(0, 1) == 1)
               drain_pipeline();
         end
         drain_pipeline();
      end

      // let any stray responses show up
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: feistel_block_cipher_64.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_key_sched.sv
hw/rtl/fbc_round.sv
hw/rtl/feistel_block_cipher_64.sv
hw/rtl/fbc_checker.sv
dv/testbench.sv
